@@ rtl/shc_pkg.sv @@
// Shared widths, constants, register indexes and controller/datapath link types.
package shc_pkg;

   localparam int MAG_W      = 16;
   localparam int ANGLE_W    = 15;
   localparam int STAMP_W    = 32;
   localparam int GAP_W      = 24;
   localparam int TOL_W      = 14;
   localparam int RADIUS_W   = 16;
   localparam int PATTERN_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Divider: quotient bits, step counter width
   localparam int QUOT_W     = 16;
   localparam int DIV_CNT_W  = $clog2(QUOT_W);

   // Recording floor, 0.15 in Q1.15
   localparam logic [MAG_W-1:0] HIT_FLOOR = 16'd4915;

   // Reference average: floor(x/10) as (x * REF_RECIP) >> REF_SHIFT for x < 2^20
   localparam int REF_SUM_W = 20;
   localparam logic [REF_SUM_W-1:0] REF_RECIP = 20'd838861;
   localparam int REF_SHIFT = 23;

   localparam logic [RADIUS_W-1:0] RADIUS_BASE = 16'd7864;
   localparam logic [RADIUS_W-1:0] RADIUS_SPAN = 16'd57672;

   // Configuration reset values
   localparam logic [MAG_W-1:0] STRONG_LEVEL_RST   = 16'd39322;
   localparam logic [MAG_W-1:0] STRONG_RISE_RST    = 16'd9830;
   localparam logic [GAP_W-1:0] RHYTHM_GAP_MIN_RST = 24'd300000;
   localparam logic [GAP_W-1:0] RHYTHM_GAP_MAX_RST = 24'd700000;
   localparam logic [TOL_W-1:0] RHYTHM_ANGLE_RST   = 14'd1787;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRONG_LEVEL   = 3'd0,
      CSR_STRONG_RISE    = 3'd1,
      CSR_RHYTHM_GAP_MIN = 3'd2,
      CSR_RHYTHM_GAP_MAX = 3'd3,
      CSR_RHYTHM_ANGLE   = 3'd4
   } csr_idx_type;

   typedef enum logic [PATTERN_W-1:0] {
      PAT_WEAK   = 2'd0,
      PAT_MEDIUM = 2'd1,
      PAT_STRONG = 2'd2
   } pattern_type;

   typedef struct packed {
      logic idle;
      logic update;
      logic div_init;
      logic div_step;
      logic square;
      logic scale;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic accept;
      logic recorded;
      logic out_free;
   } status_type;

endpackage

@@ rtl/shc_if.sv @@
// Valid/ready channel interfaces for events, results and register writes.
interface shc_req_if import shc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [MAG_W-1:0]          magnitude;
   logic signed [ANGLE_W-1:0] azimuth;
   logic signed [ANGLE_W-1:0] elevation;
   logic                      is_background;
   logic [STAMP_W-1:0]        stamp;

   modport source (output valid, magnitude, azimuth, elevation, is_background, stamp,
                   input ready);
   modport sink   (input valid, magnitude, azimuth, elevation, is_background, stamp,
                   output ready);
endinterface

interface shc_rsp_if import shc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 recorded;
   logic [RADIUS_W-1:0]  radius_factor;
   logic [PATTERN_W-1:0] pattern;

   modport source (output valid, recorded, radius_factor, pattern, input ready);
   modport sink   (input valid, recorded, radius_factor, pattern, output ready);
endinterface

interface shc_csr_if import shc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/shc_ctrl.sv @@
// Sequencer: steps one item through update, then for hits divide, square and scale, then output.
module shc_ctrl import shc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_SQUARE,
      ST_SCALE,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // skip the radius work for items that are not hits
            state_in = status.recorded ? ST_DIV_INIT : ST_FINISH;
         end
         ST_DIV_INIT: begin
            count_in = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            count_in = count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(QUOT_W - 1)) state_in = ST_SQUARE;
         end
         ST_SQUARE: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_FINISH;
         ST_FINISH: begin
            // hold until the output register can take the item
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.idle     = (state_ff == ST_IDLE);
      cmd.update   = (state_ff == ST_UPDATE);
      cmd.div_init = (state_ff == ST_DIV_INIT);
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.square   = (state_ff == ST_SQUARE);
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.finish   = (state_ff == ST_FINISH);
   end

endmodule

@@ rtl/shc_datapath.sv @@
// Datapath: registers, hit history, classifier, serial divider and radius arithmetic.
module shc_datapath import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   shc_req_if.sink     req_chan,
   shc_rsp_if.source   rsp_chan,
   shc_csr_if.sink     csr_chan
);

   // Configuration
   logic [MAG_W-1:0] strong_level_ff, strong_rise_ff;
   logic [GAP_W-1:0] gap_min_ff, gap_max_ff;
   logic [TOL_W-1:0] angle_ff;

   // Captured item
   logic [MAG_W-1:0]          mag_ff;
   logic signed [ANGLE_W-1:0] az_ff, el_ff;
   logic [STAMP_W-1:0]        stamp_ff;
   logic                      rec_ff;

   // Hit history
   logic [MAG_W-1:0]          ref_ff, prev_level_ff;
   logic                      have_prev_ff;
   logic [STAMP_W-1:0]        prev_stamp_ff;
   logic signed [ANGLE_W-1:0] prev_az_ff, prev_el_ff;
   pattern_type               pattern_ff, pattern_in;

   // Divider and radius
   logic [QUOT_W+1:0] den_ff, den_in;
   logic [QUOT_W+1:0] rem_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              sat_ff;
   logic [32:0]       sq_ff;
   logic [32:0]       rp_ff;

   // Output register
   logic                rsp_valid_ff;
   logic                rsp_rec_ff;
   logic [RADIUS_W-1:0] rsp_radius_ff, radius_in;
   pattern_type         rsp_pattern_ff;

   logic accept, out_free, load_out;

   assign req_chan.ready = cmd.idle;
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign load_out = cmd.finish && out_free;

   assign status.accept   = accept;
   assign status.recorded = rec_ff;
   assign status.out_free = out_free;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strong_level_ff <= STRONG_LEVEL_RST;
         strong_rise_ff  <= STRONG_RISE_RST;
         gap_min_ff      <= RHYTHM_GAP_MIN_RST;
         gap_max_ff      <= RHYTHM_GAP_MAX_RST;
         angle_ff        <= RHYTHM_ANGLE_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_STRONG_LEVEL:   strong_level_ff <= csr_chan.data[MAG_W-1:0];
            CSR_STRONG_RISE:    strong_rise_ff  <= csr_chan.data[MAG_W-1:0];
            CSR_RHYTHM_GAP_MIN: gap_min_ff      <= csr_chan.data[GAP_W-1:0];
            CSR_RHYTHM_GAP_MAX: gap_max_ff      <= csr_chan.data[GAP_W-1:0];
            CSR_RHYTHM_ANGLE:   angle_ff        <= csr_chan.data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff   <= req_chan.magnitude;
         az_ff    <= req_chan.azimuth;
         el_ff    <= req_chan.elevation;
         stamp_ff <= req_chan.stamp;
         rec_ff   <= !req_chan.is_background && (req_chan.magnitude > HIT_FLOOR);
      end
   end

   // Reference average (7*ref + 3*mag + 5) / 10 by reciprocal multiply; mag itself while ref is zero
   logic [REF_SUM_W-1:0]   ref_sum;
   logic [2*REF_SUM_W-1:0] ref_prod;
   logic [MAG_W-1:0]       ref_in;

   assign ref_sum = ({4'b0, ref_ff} << 3) - {4'b0, ref_ff}
                  + ({4'b0, mag_ff} << 1) + {4'b0, mag_ff} + 20'd5;
   assign ref_prod = {{REF_SUM_W{1'b0}}, ref_sum} * {{REF_SUM_W{1'b0}}, REF_RECIP};
   assign ref_in   = (ref_ff == '0) ? mag_ff : ref_prod[REF_SHIFT +: MAG_W];

   // Classification against the previous hit
   logic [MAG_W:0]         rise;
   logic [STAMP_W-1:0]     gap;
   logic signed [ANGLE_W:0] az_diff, el_diff;
   logic [ANGLE_W:0]       az_abs, el_abs;
   logic                   is_strong, gap_ok, angle_ok;

   assign rise    = {1'b0, mag_ff} - {1'b0, prev_level_ff};
   assign is_strong = (mag_ff > strong_level_ff) &&
                      ($signed(rise) > $signed({1'b0, strong_rise_ff}));
   assign gap     = stamp_ff - prev_stamp_ff;
   assign gap_ok  = (gap >= {8'b0, gap_min_ff}) && (gap <= {8'b0, gap_max_ff});
   assign az_diff = {az_ff[ANGLE_W-1], az_ff} - {prev_az_ff[ANGLE_W-1], prev_az_ff};
   assign el_diff = {el_ff[ANGLE_W-1], el_ff} - {prev_el_ff[ANGLE_W-1], prev_el_ff};
   assign az_abs  = az_diff[ANGLE_W] ? -az_diff : az_diff;
   assign el_abs  = el_diff[ANGLE_W] ? -el_diff : el_diff;
   assign angle_ok = (az_abs < {2'b0, angle_ff}) && (el_abs < {2'b0, angle_ff});

   always_comb begin
      if (is_strong)                            pattern_in = PAT_STRONG;
      else if (have_prev_ff && gap_ok && angle_ok) pattern_in = PAT_MEDIUM;
      else                                      pattern_in = PAT_WEAK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff        <= '0;
         prev_level_ff <= '0;
         have_prev_ff  <= 1'b0;
         prev_stamp_ff <= '0;
         prev_az_ff    <= '0;
         prev_el_ff    <= '0;
         pattern_ff    <= PAT_WEAK;
      end else if (cmd.update && rec_ff) begin
         ref_ff        <= ref_in;
         prev_level_ff <= mag_ff;
         have_prev_ff  <= 1'b1;
         prev_stamp_ff <= stamp_ff;
         prev_az_ff    <= az_ff;
         prev_el_ff    <= el_ff;
         pattern_ff    <= pattern_in;
      end
   end

   // Restoring divider: (mag << 17) / (3*ref), saturated at 1.0
   logic [QUOT_W+2:0] rem_dbl, rem_sub;
   logic              rem_ge;
   logic [QUOT_W:0]   quiet;
   logic [33:0]       sq_full;
   logic [32:0]       sq_round, rp_full, rp_round;
   logic [QUOT_W:0]   q2, rad_sum;

   assign den_in  = {2'b0, ref_ff} + {1'b0, ref_ff, 1'b0};
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, den_ff};
   assign rem_ge  = (rem_dbl >= {1'b0, den_ff});

   assign quiet    = sat_ff ? '0 : (17'h10000 - {1'b0, quot_ff});
   assign sq_full  = {17'b0, quiet} * {17'b0, quiet};
   assign sq_round = sq_ff + 33'd32768;
   assign q2       = sq_round[32:16];
   assign rp_full  = {17'b0, RADIUS_SPAN} * {16'b0, q2};
   assign rp_round = rp_ff + 33'd32768;
   assign rad_sum  = rp_round[32:16] + {1'b0, RADIUS_BASE};
   assign radius_in = rad_sum[QUOT_W] ? '1 : rad_sum[RADIUS_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         den_ff <= den_in;
         rem_ff <= {1'b0, mag_ff, 1'b0};
         sat_ff <= (den_in == '0) || ({1'b0, mag_ff, 1'b0} >= den_in);
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_ge ? rem_sub[QUOT_W+1:0] : rem_dbl[QUOT_W+1:0];
         quot_ff <= {quot_ff[QUOT_W-2:0], rem_ge};
      end
      if (cmd.square) sq_ff <= sq_full[32:0];
      if (cmd.scale)  rp_ff <= rp_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_rec_ff     <= rec_ff;
         rsp_radius_ff  <= rec_ff ? radius_in : '0;
         rsp_pattern_ff <= rec_ff ? pattern_ff : PAT_WEAK;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.recorded      = rsp_rec_ff;
   assign rsp_chan.radius_factor = rsp_radius_ff;
   assign rsp_chan.pattern       = rsp_pattern_ff;

endmodule

@@ rtl/sound_hit_classifier.sv @@
// Top level of the sound hit classifier: sequencer plus datapath.
// Takes one sound-direction event at a time and returns one result item per event.
// A hit (not background, magnitude above 0.15) goes from one accepted item to the
// next through these steps: update the reference level and classify, set up the
// divider, run the one-bit-per-cycle restoring divider that forms the 16-bit
// quotient 2*magnitude/(3*reference), then a squaring and a scaling multiply, and
// load the output register. A non-hit skips the divider and multiplies. The input is
// ready only while the sequencer is idle; a finished item waits in the output
// register while the next event is taken, and the sequencer holds its final step
// only when a second result would overwrite an untaken one. Configuration
// registers are always ready and should be written while no event is in flight.
module sound_hit_classifier import shc_pkg::*; (
   input logic       clock,
   input logic       reset,
   shc_req_if.sink   req_chan,
   shc_rsp_if.source rsp_chan,
   shc_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;

   shc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   shc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

`ifndef SYNTHESIS
   // one item in flight: input closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("input accepted while an item is in flight");

   // a finishing item that finds room is presented next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish && status.out_free |=> rsp_chan.valid)
      else $error("finished item not presented");

   // items that are not hits carry no radius and no pattern
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.recorded |->
         rsp_chan.radius_factor == '0 && rsp_chan.pattern == PAT_WEAK)
      else $error("non-hit item with radius or pattern");

   // a hit never lies nearer than the base radius
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.recorded |-> rsp_chan.radius_factor >= RADIUS_BASE)
      else $error("hit radius below base");
`endif

endmodule
